@@ rtl/core/tofvc_pkg.sv @@
// Shared types and constants for the two-octet float value codec.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tofvc_pkg;

  localparam int unsigned ValW  = 27;  // stored value, hundredths, signed
  localparam int unsigned MantW = 12;  // sign plus 11-bit mantissa
  localparam int unsigned ExpW  = 4;
  localparam int unsigned LenW  = 4;

  localparam logic [LenW-1:0]  MinLen = LenW'(4);
  localparam logic [ExpW-1:0]  ExpMax = ExpW'(15);
  localparam logic [ValW-1:0]  PosLim = ValW'(2047);
  localparam logic [ValW-1:0]  NegLim = ValW'(2048);
  localparam logic [MantW-1:0] PosSat = MantW'(2047);
  localparam logic [MantW-1:0] NegSat = MantW'(2048);

  typedef logic signed [ValW-1:0] val_t;

  typedef enum logic {
    OpRecv = 1'b0,
    OpSet  = 1'b1
  } opcode_e;

  // control from the sequencer to the shift unit
  typedef struct packed {
    logic load;
    logic shl;
    logic shr;
    logic neg;
  } shift_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/tofvc_in_if.sv @@
// Input channel of the codec: valid/ready plus one input word.
// Depends on tofvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tofvc_in_if
  import tofvc_pkg::*;
();
  logic                valid;
  logic                ready;
  opcode_e             opcode;
  logic [LenW-1:0]     payload_len;
  logic [7:0]          payload_hi;
  logic [7:0]          payload_lo;
  val_t                set_hundredths;

  modport source (output valid, opcode, payload_len, payload_hi, payload_lo,
                  set_hundredths, input ready);
  modport sink   (input valid, opcode, payload_len, payload_hi, payload_lo,
                  set_hundredths, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tofvc_out_if.sv @@
// Output channel of the codec: valid/ready plus one result word.
// Depends on tofvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tofvc_out_if
  import tofvc_pkg::*;
();
  logic       valid;
  logic       ready;
  logic       send_valid;
  logic [7:0] send_hi;
  logic [7:0] send_lo;
  logic       updated;
  logic       dropped;
  val_t       value_hundredths;

  modport source (output valid, send_valid, send_hi, send_lo, updated, dropped,
                  value_hundredths, input ready);
  modport sink   (input valid, send_valid, send_hi, send_lo, updated, dropped,
                  value_hundredths, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tofvc_shift_unit.sv @@
// Shared one-bit shifter with range compare, used for both decode and encode.
// Depends on tofvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tofvc_shift_unit
  import tofvc_pkg::*;
(
  input  wire logic            clk_i,
  input  wire shift_cmd_t      cmd_i,
  input  wire logic [ValW-1:0] load_i,
  output logic [ValW-1:0]      work_o,
  output logic                 over_o
);

  logic [ValW-1:0] work_q, work_d;

  always_comb begin
    work_d = work_q;
    if (cmd_i.load) begin
      work_d = load_i;
    end else if (cmd_i.shl) begin
      work_d = {work_q[ValW-2:0], 1'b0};
    end else if (cmd_i.shr) begin
      work_d = {1'b0, work_q[ValW-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  // magnitude still outside the mantissa range (negative side reaches 2048)
  assign over_o = cmd_i.neg ? (work_q > NegLim) : (work_q > PosLim);
  assign work_o = work_q;

endmodule

`default_nettype wire

@@ rtl/core/two_octet_float_value_codec_unit.sv @@
// Top level of the two-octet float value codec: sequencer, value store,
// result register. Depends on tofvc_pkg, tofvc_in_if, tofvc_out_if, tofvc_shift_unit.
`timescale 1ns / 1ps
`default_nettype none

// Holds one value in hundredths with a valid flag. A received telegram
// (opcode 0) decodes sign/exponent/mantissa as mantissa * 2^exponent; a
// telegram shorter than 4 bytes is reported as dropped. A local set (opcode 1)
// stores the value and returns its encoded two-byte word when the value
// changed, the object was not yet valid, or force_send is set. Every input
// word yields exactly one result word. One word at a time is in flight; it
// is handled by a one-bit shifter stepped by the sequencer. A dropped
// telegram goes straight to the result step; a received one is shifted left
// by its exponent (up to 15), and a set is shifted right until its magnitude
// fits the mantissa range (at most 15 shifts). A new word is accepted while
// the previous result still waits in the output register; the result step
// waits only if that register is still full.
module two_octet_float_value_codec_unit
  import tofvc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  tofvc_in_if.sink        in_i,
  tofvc_out_if.source     out_o,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDec  = 2'd1;
  localparam logic [1:0] StEnc  = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0]      state_q, state_d;
  opcode_e         op_q;
  logic            drop_q, neg_q;
  logic [ExpW-1:0] ex_q, ex_d;
  val_t            set_q;
  val_t            stored_q;
  logic            valid_q;
  logic            force_q;

  logic            out_valid_q;
  logic            out_send_q, out_upd_q, out_drop_q;
  logic [7:0]      out_hi_q, out_lo_q;
  val_t            out_val_q;

  logic            accept;
  logic            fin_ok;
  shift_cmd_t      cmd;
  logic [ValW-1:0] load_val;
  logic [ValW-1:0] work;
  logic            over;

  val_t            nv;
  logic            change, commit, send;
  logic [MantW-1:0] mag12, tw;
  logic [7:0]      enc_hi, enc_lo;

  assign in_i.ready = (state_q == StIdle);
  assign accept     = in_i.valid && in_i.ready;
  assign fin_ok     = (state_q == StFin) && (!out_valid_q || out_o.ready);

  // decode loads the sign-extended mantissa, encode loads the magnitude
  always_comb begin
    if (in_i.opcode == OpRecv) begin
      load_val = {{(ValW - MantW){in_i.payload_hi[7]}}, in_i.payload_hi[7],
                  in_i.payload_hi[2:0], in_i.payload_lo};
    end else if (in_i.set_hundredths[ValW-1]) begin
      load_val = ValW'(0) - ValW'(in_i.set_hundredths);
    end else begin
      load_val = ValW'(in_i.set_hundredths);
    end
  end

  tofvc_shift_unit u_shift (
    .clk_i  (clk_i),
    .cmd_i  (cmd),
    .load_i (load_val),
    .work_o (work),
    .over_o (over)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    ex_d     = ex_q;
    cmd.load = accept;
    cmd.shl  = 1'b0;
    cmd.shr  = 1'b0;
    cmd.neg  = neg_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_i.opcode == OpSet) begin
            state_d = StEnc;
            ex_d    = '0;
          end else if (in_i.payload_len < MinLen) begin
            state_d = StFin;
            ex_d    = '0;
          end else begin
            state_d = StDec;
            ex_d    = in_i.payload_hi[6:3];
          end
        end
      end
      StDec: begin
        if (ex_q == '0) begin
          state_d = StFin;
        end else begin
          cmd.shl = 1'b1;
          ex_d    = ex_q - ExpW'(1);
        end
      end
      StEnc: begin
        if (over && ex_q != ExpMax) begin
          cmd.shr = 1'b1;
          ex_d    = ex_q + ExpW'(1);
        end else begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (fin_ok) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // result of the finished word
  always_comb begin
    nv     = (op_q == OpSet) ? set_q : val_t'(work);
    change = !valid_q || (nv != stored_q);
    commit = (op_q == OpSet) ? (change || force_q) : (!drop_q && change);
    send   = (op_q == OpSet) && commit;
    // saturate if fifteen halvings were not enough
    if (over) begin
      mag12 = neg_q ? NegSat : PosSat;
    end else begin
      mag12 = work[MantW-1:0];
    end
    tw     = neg_q ? (MantW'(0) - mag12) : mag12;
    enc_hi = send ? {neg_q, ex_q, tw[10:8]} : 8'h00;
    enc_lo = send ? tw[7:0] : 8'h00;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ex_q        <= '0;
      stored_q    <= '0;
      valid_q     <= 1'b0;
      force_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ex_q    <= ex_d;
      if (cfg_we_i) begin
        force_q <= cfg_wdata_i;
      end
      if (fin_ok && commit) begin
        stored_q <= nv;
        valid_q  <= 1'b1;
      end
      if (fin_ok) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_i.opcode;
      drop_q <= (in_i.opcode == OpRecv) && (in_i.payload_len < MinLen);
      neg_q  <= (in_i.opcode == OpSet) && in_i.set_hundredths[ValW-1];
      set_q  <= in_i.set_hundredths;
    end
    if (fin_ok) begin
      out_send_q <= send;
      out_hi_q   <= enc_hi;
      out_lo_q   <= enc_lo;
      out_upd_q  <= (op_q == OpSet) ? (commit && change) : commit;
      out_drop_q <= drop_q;
      out_val_q  <= commit ? nv : stored_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.send_valid       = out_send_q;
  assign out_o.send_hi          = out_hi_q;
  assign out_o.send_lo          = out_lo_q;
  assign out_o.updated          = out_upd_q;
  assign out_o.dropped          = out_drop_q;
  assign out_o.value_hundredths = out_val_q;

`ifndef SYNTHESIS
  a_dec_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDec && ex_q != '0) |=> (ex_q == $past(ex_q) - ExpW'(1)))
    else $error("decode shift count did not step down");

  a_fin_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_ok |=> (out_valid_q && state_q == StIdle))
    else $error("finished word did not reach the result register");

  a_drop_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_drop_q) |-> (!out_send_q && !out_upd_q))
    else $error("dropped telegram reported a send or update");

  a_send_valid_obj: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_send_q || out_upd_q)) |-> valid_q)
    else $error("send or update while the object is not valid");

  a_enc_exp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEnc && ex_q == ExpMax) |=> (state_q == StFin))
    else $error("encode shifted past the largest exponent");
`endif

endmodule

`default_nettype wire
